### sv/mco_pkg.sv
// ----------------------------------------------------------------------------
// mco_pkg: shared types and constants for the midpoint circle outline block
// Holds the field types, register indexes, op codes and reset values of the
// configuration registers.
// ----------------------------------------------------------------------------
package mco_pkg;

	// Pixel coordinate and octant point component
	typedef logic [7:0] coord_t;

	// Radius of a circle, 0..127
	typedef logic [6:0] radius_t;

	// Decision error, two's complement, wraps at ten bits
	typedef logic [9:0] err_t;

	// Result slot within one item, eight pixels
	typedef logic [2:0] slot_t;

	// Input op codes
	typedef enum logic {
		OP_START = 1'b0,
		OP_STEP  = 1'b1
	} op_t;

	// Configuration register indexes
	typedef enum logic {
		REG_WIDTH  = 1'b0,
		REG_HEIGHT = 1'b1
	} reg_idx_t;

	localparam coord_t WIDTH_RESET  = 8'd160;
	localparam coord_t HEIGHT_RESET = 8'd100;
	localparam slot_t  SLOT_LAST    = 3'd7;

endpackage

### sv/mco_in_if.sv
// ----------------------------------------------------------------------------
// mco_in_if: input item channel
// Valid/ready channel carrying one circle command (start or step).
// ----------------------------------------------------------------------------
interface mco_in_if;
	logic             valid;
	logic             ready;
	logic             op;
	mco_pkg::coord_t  center_x;
	mco_pkg::coord_t  center_y;
	mco_pkg::radius_t radius;

	modport source (output valid, output op, output center_x, output center_y,
		output radius, input ready);
	modport sink (input valid, input op, input center_x, input center_y,
		input radius, output ready);
endinterface

### sv/mco_out_if.sv
// ----------------------------------------------------------------------------
// mco_out_if: result item channel
// Valid/ready channel carrying one outline pixel or a done marker.
// ----------------------------------------------------------------------------
interface mco_out_if;
	logic            valid;
	logic            ready;
	mco_pkg::coord_t pix_x;
	mco_pkg::coord_t pix_y;
	logic            visible;
	logic            last;
	logic            done_res;

	modport source (output valid, output pix_x, output pix_y, output visible,
		output last, output done_res, input ready);
	modport sink (input valid, input pix_x, input pix_y, input visible,
		input last, input done_res, output ready);
endinterface

### sv/midpoint_circle_outline.sv
// ----------------------------------------------------------------------------
// midpoint_circle_outline: midpoint circle outline pixel generator
// Walks one octant of a circle and sends the eight symmetric pixels per point.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch  : start item (op 0: centre and radius) or step item (op 1).
//   out_ch : result items. A start or an active step gives eight pixels, the
//            eighth with last set. A step past the diagonal, or before any
//            start, gives one item with done_res and last set.
//   cfg_*  : write port for width_limit (index 0) and height_limit (index 1).
//            Write only while the block is idle; the block does not enforce it.
// Timing: an accepted item is latched into the work register, whose results
//   then move into the output register one result per cycle while out_ch.ready
//   does not stall them. A pixel item occupies the work register for eight
//   results, a done item for one. The next item is accepted in the cycle
//   the previous one sends its final result, so a steady stream is limited
//   by the single pixel lane of the output register.
// Reset: clears the point, error, centre and active flag, loads the limits
//   with 160 and 100, and empties the work and output registers.
// Stall: while out_ch.ready is low the output register holds and the slot
//   counter waits; in_ch.ready stays low until the last result can move.
// ----------------------------------------------------------------------------
module midpoint_circle_outline (
	input  logic              clk,
	input  logic              arst_n,
	mco_in_if.sink            in_ch,
	mco_out_if.source         out_ch,
	input  logic              cfg_we,
	input  mco_pkg::reg_idx_t cfg_idx,
	input  mco_pkg::coord_t   cfg_data
);

	// Configuration registers
	mco_pkg::coord_t width_q;
	mco_pkg::coord_t height_q;

	// Circle state
	mco_pkg::coord_t pt_x_q;
	mco_pkg::coord_t pt_y_q;
	mco_pkg::err_t   err_q;
	mco_pkg::coord_t cen_x_q;
	mco_pkg::coord_t cen_y_q;
	logic            act_q;

	// Work register: point being emitted
	logic            wk_busy_q;
	logic            wk_done_q;
	mco_pkg::coord_t wk_x_q;
	mco_pkg::coord_t wk_y_q;
	mco_pkg::coord_t wk_cx_q;
	mco_pkg::coord_t wk_cy_q;
	mco_pkg::slot_t  wk_k_q;

	// Output register
	logic            out_valid_q;
	mco_pkg::coord_t out_x_q;
	mco_pkg::coord_t out_y_q;
	logic            out_vis_q;
	logic            out_last_q;
	logic            out_done_q;

	logic            adv;
	logic            emit;
	logic            wk_fin;
	logic            in_acc;
	logic            is_start;

	// Source point of the accepted item
	mco_pkg::coord_t src_x;
	mco_pkg::coord_t src_y;
	mco_pkg::err_t   src_e;
	mco_pkg::err_t   x_ext;
	mco_pkg::err_t   y_ext;
	mco_pkg::err_t   x_nxt;
	mco_pkg::err_t   y_nxt;
	mco_pkg::err_t   e_nxt;
	logic            act_nxt;

	// Pixel of the current slot
	logic            swap;
	logic            neg_a;
	logic            neg_b;
	mco_pkg::coord_t off_a;
	mco_pkg::coord_t off_b;
	mco_pkg::coord_t pix_x;
	mco_pkg::coord_t pix_y;

	// Handshake control
	assign adv    = !out_valid_q || out_ch.ready;
	assign emit   = wk_busy_q && adv;
	assign wk_fin = wk_done_q || (wk_k_q == mco_pkg::SLOT_LAST);
	assign in_ch.ready = !wk_busy_q || (adv && wk_fin);
	assign in_acc = in_ch.valid && in_ch.ready;
	assign is_start = (in_ch.op == mco_pkg::OP_START);

	// Pick the point to emit and compute its successor
	always_comb begin
		if (is_start) begin
			src_x = {1'b0, in_ch.radius};
			src_y = '0;
			src_e = 10'd1 - {3'b000, in_ch.radius};
		end else begin
			src_x = pt_x_q;
			src_y = pt_y_q;
			src_e = err_q;
		end
		x_ext = {2'b00, src_x};
		y_ext = {2'b00, src_y};
		y_nxt = y_ext + 10'd1;
		if (src_e[9]) begin
			x_nxt = x_ext;
			e_nxt = src_e + {y_nxt[8:0], 1'b0} + 10'd1;
		end else begin
			x_nxt = x_ext - 10'd1;
			e_nxt = src_e + {(y_nxt[8:0] - x_nxt[8:0] + 9'd1), 1'b0};
		end
		act_nxt = ($signed(x_nxt) >= $signed(y_nxt));
	end

	// Form the pixel of the current slot from the octant point
	always_comb begin
		swap  = wk_k_q[0];
		neg_a = wk_k_q[2] ^ wk_k_q[1];
		neg_b = wk_k_q[2];
		off_a = swap ? wk_y_q : wk_x_q;
		off_b = swap ? wk_x_q : wk_y_q;
		pix_x = neg_a ? (wk_cx_q - off_a) : (wk_cx_q + off_a);
		pix_y = neg_b ? (wk_cy_q - off_b) : (wk_cy_q + off_b);
	end

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= mco_pkg::WIDTH_RESET;
			height_q <= mco_pkg::HEIGHT_RESET;
		end else if (cfg_we) begin
			case (cfg_idx)
				mco_pkg::REG_WIDTH:  width_q  <= cfg_data;
				mco_pkg::REG_HEIGHT: height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Update circle state on each accepted item that draws a point
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pt_x_q  <= '0;
			pt_y_q  <= '0;
			err_q   <= '0;
			cen_x_q <= '0;
			cen_y_q <= '0;
			act_q   <= 1'b0;
		end else if (in_acc && (is_start || act_q)) begin
			if (is_start) begin
				cen_x_q <= in_ch.center_x;
				cen_y_q <= in_ch.center_y;
			end
			pt_x_q <= x_nxt[7:0];
			pt_y_q <= y_nxt[7:0];
			err_q  <= e_nxt;
			act_q  <= act_nxt;
		end
	end

	// Load the work register on accept, advance the slot on each emit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wk_busy_q <= 1'b0;
			wk_done_q <= 1'b0;
			wk_k_q    <= '0;
		end else if (in_acc) begin
			wk_busy_q <= 1'b1;
			wk_done_q <= !is_start && !act_q;
			wk_k_q    <= '0;
		end else if (emit) begin
			wk_k_q <= wk_k_q + 3'd1;
			if (wk_fin) begin
				wk_busy_q <= 1'b0;
			end
		end
	end

	// Hold the point and centre of the item in the work register
	always_ff @(posedge clk) begin
		if (in_acc) begin
			wk_x_q  <= src_x;
			wk_y_q  <= src_y;
			wk_cx_q <= is_start ? in_ch.center_x : cen_x_q;
			wk_cy_q <= is_start ? in_ch.center_y : cen_y_q;
		end
	end

	// Output register valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= wk_busy_q;
		end
	end

	// Output register payload
	always_ff @(posedge clk) begin
		if (emit) begin
			if (wk_done_q) begin
				out_x_q    <= '0;
				out_y_q    <= '0;
				out_vis_q  <= 1'b0;
				out_last_q <= 1'b1;
				out_done_q <= 1'b1;
			end else begin
				out_x_q    <= pix_x;
				out_y_q    <= pix_y;
				out_vis_q  <= (pix_x < width_q) && (pix_y < height_q);
				out_last_q <= (wk_k_q == mco_pkg::SLOT_LAST);
				out_done_q <= 1'b0;
			end
		end
	end

	assign out_ch.valid    = out_valid_q;
	assign out_ch.pix_x    = out_x_q;
	assign out_ch.pix_y    = out_y_q;
	assign out_ch.visible  = out_vis_q;
	assign out_ch.last     = out_last_q;
	assign out_ch.done_res = out_done_q;

`ifndef ASSERT_OFF
	// A done marker is always the final result of its item
	a_done_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_done_q |-> out_last_q)
		else $error("done result without last");

	// Every emit fills the output register
	a_emit_fill: assert property (@(posedge clk) disable iff (!arst_n)
		emit |=> out_valid_q)
		else $error("emitted result lost");

	// An active circle keeps its point inside the radius range
	a_act_range: assert property (@(posedge clk) disable iff (!arst_n)
		act_q |-> !pt_x_q[7])
		else $error("active point out of range");

	// The slot counter waits while the receiver stalls
	a_slot_hold: assert property (@(posedge clk) disable iff (!arst_n)
		wk_busy_q && !adv |=> $stable(wk_k_q))
		else $error("slot advanced during stall");
`endif

endmodule

### tb/midpoint_circle_outline_tb.sv
// ----------------------------------------------------------------------------
// midpoint_circle_outline_tb: self-checking testbench for the circle outline
// Drives start and step items into the block and predicts every outline pixel
// and done marker with an independent octant walker. Results are checked in
// order, field by field, under random idling on both channels. A long output
// hold-off, a drain pause and several limit settings are also run.
// ----------------------------------------------------------------------------
module midpoint_circle_outline_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int STALL_LIMIT = 3000;
	localparam int HOLD_CYCLES = 300;
	localparam int SETTLE      = 4;
	localparam int TAIL        = 16;

	typedef struct packed {
		mco_pkg::coord_t pix_x;
		mco_pkg::coord_t pix_y;
		logic            visible;
		logic            last;
		logic            done_res;
	} outline_res_t;

	logic               clk;
	logic               arst_n;
	logic               cfg_we;
	mco_pkg::reg_idx_t  cfg_idx;
	mco_pkg::coord_t    cfg_data;

	mco_in_if  in_ch();
	mco_out_if out_ch();

	midpoint_circle_outline u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_ch    (in_ch),
		.out_ch   (out_ch),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data)
	);

	// Octant walker state and limits
	mco_pkg::coord_t pt_x;
	mco_pkg::coord_t pt_y;
	mco_pkg::err_t   decision_q;
	mco_pkg::coord_t ctr_col;
	mco_pkg::coord_t ctr_row;
	bit              circle_active;
	mco_pkg::coord_t lim_w;
	mco_pkg::coord_t lim_h;

	outline_res_t expected_outline[$];

	int fault_count;
	int items_sent;
	int idle_cycles;
	bit quiet;
	bit hold_req;

	// Clock
	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	// Clear walker state and limits to their reset values
	function automatic void reset_walker();
		pt_x          = '0;
		pt_y          = '0;
		decision_q    = '0;
		ctr_col       = '0;
		ctr_row       = '0;
		circle_active = 1'b0;
		lim_w         = mco_pkg::WIDTH_RESET;
		lim_h         = mco_pkg::HEIGHT_RESET;
	endfunction

	// Emit the eight mirrored pixels of the current point, then advance it
	function automatic void emit_octant_point();
		int x;
		int y;
		int e;
		int dx[8];
		int dy[8];
		outline_res_t res;
		x = int'(pt_x);
		y = int'(pt_y);
		e = int'($signed(decision_q));
		dx = '{x, y, -x, -y, -x, -y, x, y};
		dy = '{y, x, y, x, -y, -x, -y, -x};
		for (int k = 0; k < 8; k++) begin
			res.pix_x    = mco_pkg::coord_t'(int'(ctr_col) + dx[k]);
			res.pix_y    = mco_pkg::coord_t'(int'(ctr_row) + dy[k]);
			res.visible  = (res.pix_x < lim_w) && (res.pix_y < lim_h);
			res.last     = (k == 7);
			res.done_res = 1'b0;
			expected_outline.push_back(res);
		end
		y++;
		if (e < 0) begin
			e += 2 * y + 1;
		end else begin
			x--;
			e += 2 * (y - x + 1);
		end
		circle_active = (x >= y);
		pt_x          = mco_pkg::coord_t'(x);
		pt_y          = mco_pkg::coord_t'(y);
		decision_q    = mco_pkg::err_t'(e);
	endfunction

	// Work out the results of one accepted item
	function automatic void predict_outline(mco_pkg::op_t op, mco_pkg::coord_t cx,
		mco_pkg::coord_t cy, mco_pkg::radius_t r);
		outline_res_t res;
		if (op == mco_pkg::OP_START) begin
			ctr_col       = cx;
			ctr_row       = cy;
			pt_x          = mco_pkg::coord_t'(r);
			pt_y          = '0;
			decision_q    = mco_pkg::err_t'(1 - int'(r));
			circle_active = 1'b1;
			emit_octant_point();
		end else if (circle_active) begin
			emit_octant_point();
		end else begin
			res = '{pix_x: '0, pix_y: '0, visible: 1'b0, last: 1'b1, done_res: 1'b1};
			expected_outline.push_back(res);
		end
	endfunction

	// Offer one item, idling now and then, and hold it until accepted
	task automatic send_item(mco_pkg::op_t op, mco_pkg::coord_t cx, mco_pkg::coord_t cy,
		mco_pkg::radius_t r);
		while (!quiet && $urandom_range(99) < 8) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		in_ch.valid    <= 1'b1;
		in_ch.op       <= op;
		in_ch.center_x <= cx;
		in_ch.center_y <= cy;
		in_ch.radius   <= r;
		@(posedge clk);
		while (!in_ch.ready)
			@(posedge clk);
		predict_outline(op, cx, cy, r);
		items_sent++;
	endtask

	// Step item with random ignored fields
	task automatic send_step();
		send_item(mco_pkg::OP_STEP, mco_pkg::coord_t'($urandom_range(255)),
			mco_pkg::coord_t'($urandom_range(255)),
			mco_pkg::radius_t'($urandom_range(127)));
	endtask

	// Start a circle, walk it for up to max_steps, then one more step
	task automatic send_walk(mco_pkg::coord_t cx, mco_pkg::coord_t cy, mco_pkg::radius_t r,
		int max_steps);
		int steps;
		steps = 0;
		send_item(mco_pkg::OP_START, cx, cy, r);
		while (circle_active && steps < max_steps) begin
			send_step();
			steps++;
		end
		send_step();
	endtask

	// Drop valid and wait until every expected result has arrived
	task automatic wait_drain();
		in_ch.valid <= 1'b0;
		while (expected_outline.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// Write both limits; the block must be idle
	task automatic write_limits(mco_pkg::coord_t w, mco_pkg::coord_t h);
		cfg_we   <= 1'b1;
		cfg_idx  <= mco_pkg::REG_WIDTH;
		cfg_data <= w;
		@(posedge clk);
		cfg_idx  <= mco_pkg::REG_HEIGHT;
		cfg_data <= h;
		@(posedge clk);
		cfg_we   <= 1'b0;
		lim_w = w;
		lim_h = h;
	endtask

	task automatic test_directed();
		// step with no circle started answers done
		send_step();
		// zero radius: centre eight times, then done
		send_walk(8'd80, 8'd50, 7'd0, 4);
		// largest radius around the top corner, wraps past 255
		send_item(mco_pkg::OP_START, 8'd255, 8'd255, 7'd127);
		send_step();
		send_step();
		// restart mid circle at the origin, wraps below zero
		send_item(mco_pkg::OP_START, 8'd0, 8'd0, 7'd127);
		send_step();
		// unit circle on the visibility edge
		send_walk(mco_pkg::WIDTH_RESET - 8'd1, mco_pkg::HEIGHT_RESET - 8'd1, 7'd1, 4);
		// complete walks to done, plus a step past done
		send_walk(8'd80, 8'd50, 7'd5, 8);
		send_walk(8'd0, 8'd255, 7'd3, 8);
		send_step();
	endtask

	task automatic test_limits();
		mco_pkg::coord_t w_set[4];
		mco_pkg::coord_t h_set[4];
		w_set = '{8'd1, 8'd255, mco_pkg::coord_t'($urandom_range(255, 1)),
			mco_pkg::WIDTH_RESET};
		h_set = '{8'd255, 8'd1, mco_pkg::coord_t'($urandom_range(255, 1)),
			mco_pkg::HEIGHT_RESET};
		for (int i = 0; i < 4; i++) begin
			wait_drain();
			write_limits(w_set[i], h_set[i]);
			send_walk(mco_pkg::coord_t'($urandom_range(6)),
				mco_pkg::coord_t'($urandom_range(6)),
				mco_pkg::radius_t'($urandom_range(5, 2)), 8);
		end
	endtask

	// Mostly well-formed circles, some abandoned, some stray steps and limit writes
	task automatic test_random_circles(int n_items);
		int target;
		mco_pkg::radius_t r;
		target = items_sent + n_items;
		while (items_sent < target) begin
			case ($urandom_range(11))
				0: begin
					send_step();
				end
				1: begin
					wait_drain();
					write_limits(mco_pkg::coord_t'($urandom_range(255, 1)),
						mco_pkg::coord_t'($urandom_range(255, 1)));
				end
				default: begin
					r = ($urandom_range(7) == 0) ? mco_pkg::radius_t'($urandom_range(127)) :
						mco_pkg::radius_t'($urandom_range(10));
					send_walk(mco_pkg::coord_t'($urandom_range(255)),
						mco_pkg::coord_t'($urandom_range(255)), r, $urandom_range(20));
				end
			endcase
		end
	endtask

	// Back-to-back items with no idling on either side
	task automatic test_steady_stream();
		quiet = 1'b1;
		test_random_circles(60);
		quiet = 1'b0;
	endtask

	// Hold the output off so the block fills and stalls its input
	task automatic test_output_hold_off();
		hold_req = 1'b1;
		send_walk(8'd128, 8'd64, 7'd20, 16);
	endtask

	// Pause input until everything has drained, then resume
	task automatic test_drain_pause();
		send_walk(mco_pkg::coord_t'($urandom_range(255)),
			mco_pkg::coord_t'($urandom_range(255)), 7'd9, 8);
		wait_drain();
		send_walk(mco_pkg::coord_t'($urandom_range(255)),
			mco_pkg::coord_t'($urandom_range(255)), 7'd6, 8);
	endtask

	// Stimulus
	initial begin
		arst_n         = 1'b0;
		in_ch.valid    = 1'b0;
		in_ch.op       = mco_pkg::OP_START;
		in_ch.center_x = '0;
		in_ch.center_y = '0;
		in_ch.radius   = '0;
		cfg_we         = 1'b0;
		cfg_idx        = mco_pkg::REG_WIDTH;
		cfg_data       = '0;
		quiet          = 1'b0;
		hold_req       = 1'b0;
		fault_count    = 0;
		items_sent     = 0;
		reset_walker();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_limits();
		test_random_circles(130);
		test_steady_stream();
		test_output_hold_off();
		test_drain_pause();

		wait_drain();
		repeat (TAIL) @(posedge clk);
		if (fault_count == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

	// Output ready: random stalls, quiet stretches and one long hold-off
	initial begin
		out_ch.ready = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_req) begin
				out_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_req = 1'b0;
			end else begin
				out_ch.ready <= quiet || ($urandom_range(99) >= 8);
				@(posedge clk);
			end
		end
	end

	function automatic void check_field(string name, int exp_v, int act_v);
		if (exp_v != act_v) begin
			$error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
			fault_count++;
		end
	endfunction

	// Compare each result with the oldest expectation
	always @(posedge clk) begin
		outline_res_t exp_r;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (expected_outline.size() == 0) begin
				$error("result with nothing pending: pix_x %0d pix_y %0d done_res %0b",
					out_ch.pix_x, out_ch.pix_y, out_ch.done_res);
				fault_count++;
			end else begin
				exp_r = expected_outline.pop_front();
				check_field("pix_x", int'(exp_r.pix_x), int'(out_ch.pix_x));
				check_field("pix_y", int'(exp_r.pix_y), int'(out_ch.pix_y));
				check_field("visible", int'(exp_r.visible), int'(out_ch.visible));
				check_field("last", int'(exp_r.last), int'(out_ch.last));
				check_field("done_res", int'(exp_r.done_res), int'(out_ch.done_res));
			end
		end
	end

	// Watchdog: end the run when nothing moves for too long
	always @(posedge clk) begin
		if (!arst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

endmodule
